/* rtl/afs_pkg.sv */
package afs_pkg;

  // Fit strategy codes (fit_strategy register)
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIT_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_AREA_BASE    = 2'd1;
  localparam logic [1:0] CFG_AREA_LENGTH  = 2'd2;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] AREA_BASE_RST   = 16'd0;
  localparam logic [10:0] AREA_LENGTH_RST = 11'd1024;

  // Input word
  typedef struct packed {
    logic        cmd;
    logic [9:0]  map_index;
    logic        map_used;
    logic [10:0] alloc_size;
  } in_t;

  // Result word
  typedef struct packed {
    logic        found;
    logic [15:0] block_address;
  } out_t;

endpackage

/* rtl/allocation_map_fit_search.sv */
// Channel  | Ports                             | Handshake
// ---------+-----------------------------------+-------------------------------------
// input    | start, busy, in_word              | word taken when start && !busy
// result   | out_strobe, out_word              | word valid for the one strobe cycle
// config   | cfg_we, cfg_index, cfg_data       | register written when cfg_we is high
//
// An allocate scans the map one entry per cycle through the single read port of the
// flag RAM, within L, the clipped area length; a next-fit search that misses from the
// pointer scans again from offset 0. Size zero or size over L is answered without a
// scan. After reset a clearing pass writes every map entry free, with busy high.
// The receiver cannot stall: each result is a one-cycle strobe.
module allocation_map_fit_search #(
  parameter int MAP_ENTRIES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  afs_pkg::in_t     in_word,
  output logic             out_strobe,
  output afs_pkg::out_t    out_word,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int LW = $clog2(MAP_ENTRIES + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  // Configuration registers
  logic [1:0]  strat_r;
  logic [15:0] base_r;
  logic [10:0] alen_r;

  // Control
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [LW-1:0] pi_r, pi_nxt;
  logic [LW-1:0] run_start_r, run_start_nxt;
  logic [LW-1:0] run_len_r, run_len_nxt;
  logic          have_r, have_nxt;
  logic [LW-1:0] pick_len_r, pick_len_nxt;
  logic [LW-1:0] pick_start_r, pick_start_nxt;
  logic [10:0]   size_r, size_nxt;
  logic          ff_r, ff_nxt;
  logic          best_r, best_nxt;
  logic          nf_r, nf_nxt;
  logic [AW-1:0] nf_ptr_r, nf_ptr_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  afs_pkg::out_t out_word_r, out_word_nxt;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic [LW-1:0] len_eff;
  logic          accept;
  logic          close_ok;
  logic          res_done;
  logic          res_found;
  logic [LW-1:0] res_start;
  logic [31:0]   nf_sum;

  afs_ram #(
    .WIDTH (1),
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Use area clipped to the map
  assign len_eff = (32'(alen_r) > MAP_ENTRIES) ? LW'(MAP_ENTRIES) : LW'(alen_r);

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Closing the current free run against the best/worst pick; ties go to the later run
  assign close_ok = (32'(run_len_r) >= 32'(size_r)) &&
                    (!have_r || (best_r ? (run_len_r <= pick_len_r)
                                        : (run_len_r >= pick_len_r)));

  // Next-fit pointer after a hit
  assign nf_sum = 32'(run_start_r) + 32'(size_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strat_r <= afs_pkg::FIT_FIRST;
      base_r  <= afs_pkg::AREA_BASE_RST;
      alen_r  <= afs_pkg::AREA_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afs_pkg::CFG_FIT_STRATEGY: strat_r <= cfg_data[1:0];
        afs_pkg::CFG_AREA_BASE:    base_r  <= cfg_data;
        afs_pkg::CFG_AREA_LENGTH:  alen_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Map RAM write port: clearing pass or map write word
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = 1'b0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && (in_word.cmd == afs_pkg::CMD_WRITE) &&
                 (32'(in_word.map_index) < MAP_ENTRIES)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(in_word.map_index);
      ram_wdata = in_word.map_used;
    end
  end

  assign ram_raddr = AW'(cnt_r);

  // Search sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pi_nxt         = pi_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    have_nxt       = have_r;
    pick_len_nxt   = pick_len_r;
    pick_start_nxt = pick_start_r;
    size_nxt       = size_r;
    ff_nxt         = ff_r;
    best_nxt       = best_r;
    nf_nxt         = nf_r;
    nf_ptr_nxt     = nf_ptr_r;
    res_done       = 1'b0;
    res_found      = 1'b0;
    res_start      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (32'(clr_cnt_r) == MAP_ENTRIES - 1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept && (in_word.cmd == afs_pkg::CMD_ALLOC)) begin
          size_nxt     = in_word.alloc_size;
          ff_nxt       = (strat_r == afs_pkg::FIT_FIRST) || (strat_r == afs_pkg::FIT_NEXT);
          best_nxt     = (strat_r == afs_pkg::FIT_BEST);
          have_nxt     = 1'b0;
          pick_len_nxt = '0;
          run_len_nxt  = '0;
          if ((in_word.alloc_size == 11'd0) ||
              (32'(in_word.alloc_size) > 32'(len_eff))) begin
            res_done = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
            if ((strat_r == afs_pkg::FIT_NEXT) && (32'(nf_ptr_r) < 32'(len_eff))) begin
              cnt_nxt       = LW'(nf_ptr_r);
              run_start_nxt = LW'(nf_ptr_r);
              nf_nxt        = 1'b1;
            end else begin
              cnt_nxt       = '0;
              run_start_nxt = '0;
              nf_nxt        = 1'b0;
            end
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read
        if (cnt_r < len_eff) begin
          pv_nxt  = 1'b1;
          pi_nxt  = cnt_r;
          cnt_nxt = cnt_r + 1'b1;
        end

        if (pv_r) begin
          // Flag of entry pi_r is on the read data
          if (ram_rdata) begin
            if (!ff_r && close_ok) begin
              have_nxt       = 1'b1;
              pick_len_nxt   = run_len_r;
              pick_start_nxt = run_start_r;
            end
            run_len_nxt   = '0;
            run_start_nxt = pi_r + 1'b1;
          end else begin
            if (run_len_r == '0) begin
              run_start_nxt = pi_r;
            end
            run_len_nxt = run_len_r + 1'b1;
            if (ff_r && (32'(run_len_r) + 32'd1 >= 32'(size_r))) begin
              res_done  = 1'b1;
              res_found = 1'b1;
              res_start = run_start_r;
              if (nf_r) begin
                nf_ptr_nxt = (nf_sum >= 32'(len_eff)) ? '0 : AW'(nf_sum);
              end
            end
          end
        end else if (cnt_r >= len_eff) begin
          // End of a pass
          if (ff_r) begin
            if (nf_r) begin
              // Nothing from the pointer on: first fit from the area start
              nf_nxt        = 1'b0;
              cnt_nxt       = '0;
              run_start_nxt = '0;
              run_len_nxt   = '0;
            end else begin
              res_done = 1'b1;
            end
          end else begin
            res_done  = 1'b1;
            res_found = have_r || close_ok;
            res_start = close_ok ? run_start_r : pick_start_r;
          end
        end

        if (res_done) begin
          state_nxt = ST_IDLE;
          pv_nxt    = 1'b0;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result word
  always_comb begin
    out_strobe_nxt = res_done;
    out_word_nxt   = out_word_r;
    if (res_done) begin
      out_word_nxt.found         = res_found;
      out_word_nxt.block_address = res_found ? 16'(32'(base_r) + 32'(res_start)) : 16'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      pv_r         <= 1'b0;
      nf_ptr_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      pv_r         <= pv_nxt;
      nf_ptr_r     <= nf_ptr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Search datapath registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    pi_r         <= pi_nxt;
    run_start_r  <= run_start_nxt;
    run_len_r    <= run_len_nxt;
    have_r       <= have_nxt;
    pick_len_r   <= pick_len_nxt;
    pick_start_r <= pick_start_nxt;
    size_r       <= size_nxt;
    ff_r         <= ff_nxt;
    best_r       <= best_nxt;
    nf_r         <= nf_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

/* rtl/afs_ram.sv */
module afs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int MAP_ENTRIES = 1024;
  localparam int LIMIT_NS    = 10_000_000;

  typedef enum logic {ROW_SETUP, ROW_WORD} row_kind_t;

  // One line of the directed plan: a register setting or an input word
  typedef struct {
    row_kind_t     kind;
    afs_pkg::in_t  word;
    bit            typed;
    afs_pkg::out_t want;
    logic [1:0]    strategy;
    logic [15:0]   base;
    logic [10:0]   length;
  } plan_row_t;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          start     = 1'b0;
  logic          busy;
  afs_pkg::in_t  in_word   = '0;
  logic          out_strobe;
  afs_pkg::out_t out_word;
  logic          cfg_we    = 1'b0;
  logic [1:0]    cfg_index = afs_pkg::CFG_FIT_STRATEGY;
  logic [15:0]   cfg_data  = '0;

  // Shadow of the block's state and registers
  bit          used_map [MAP_ENTRIES];
  int          next_ptr      = 0;
  logic [1:0]  fit_q         = afs_pkg::FIT_FIRST;
  logic [15:0] area_base_q   = afs_pkg::AREA_BASE_RST;
  int          area_len_q    = int'(afs_pkg::AREA_LENGTH_RST);

  afs_pkg::out_t pending_blocks [$];
  plan_row_t     plan [$];

  int errors        = 0;
  int sender_idle   = 0;
  int word_count    = 0;
  int write_count   = 0;
  int search_count  = 0;
  int fit_count     = 0;
  int checked_count = 0;
  int setting_count = 0;

  allocation_map_fit_search #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Lowest start at or after from with size free entries below len
  function automatic bit first_run_from(input int from, input int len, input int size,
                                        output int at);
    int run_start;
    int run_len;
    run_start = from;
    run_len   = 0;
    at        = 0;
    for (int i = from; i < len; i++) begin
      if (used_map[i]) begin
        run_len   = 0;
        run_start = i + 1;
      end else begin
        run_len++;
        if (run_len >= size) begin
          at = run_start;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Smallest or largest maximal free run that fits; ties go to the later run
  function automatic bit sized_run(input int len, input int size, input bit want_small,
                                   output int at);
    bit have;
    int pick;
    int i;
    int s;
    int n;
    have = 1'b0;
    pick = 0;
    i    = 0;
    at   = 0;
    while (i < len) begin
      if (used_map[i]) begin
        i++;
      end else begin
        s = i;
        while (i < len && !used_map[i]) i++;
        n = i - s;
        if (n >= size && (!have || (want_small ? n <= pick : n >= pick))) begin
          have = 1'b1;
          pick = n;
          at   = s;
        end
      end
    end
    return have;
  endfunction

  // Apply one input word to the shadow map; has is set when a result word follows
  function automatic void search_map(input afs_pkg::in_t w, output bit has,
                                     output afs_pkg::out_t r);
    int len;
    int size;
    int at;
    bit ok;
    len  = (area_len_q > MAP_ENTRIES) ? MAP_ENTRIES : area_len_q;
    size = int'(w.alloc_size);
    at   = 0;
    ok   = 1'b0;
    r    = '0;
    has  = 1'b0;
    if (w.cmd == afs_pkg::CMD_WRITE) begin
      used_map[w.map_index] = w.map_used;
    end else begin
      has = 1'b1;
      if (size != 0 && size <= len) begin
        case (fit_q)
          afs_pkg::FIT_FIRST: ok = first_run_from(0, len, size, at);
          afs_pkg::FIT_NEXT: begin
            if (next_ptr < len && first_run_from(next_ptr, len, size, at)) begin
              ok       = 1'b1;
              next_ptr = (at + size >= len) ? 0 : at + size;
            end else begin
              ok = first_run_from(0, len, size, at);
            end
          end
          afs_pkg::FIT_BEST: ok = sized_run(len, size, 1'b1, at);
          default:           ok = sized_run(len, size, 1'b0, at);
        endcase
      end
      r.found         = ok;
      r.block_address = ok ? area_base_q + 16'(at) : 16'd0;
    end
  endfunction

  function automatic void add_setup(input logic [1:0] s, input logic [15:0] b,
                                    input logic [10:0] l);
    plan_row_t row;
    row          = '{kind: ROW_SETUP, default: '0};
    row.strategy = s;
    row.base     = b;
    row.length   = l;
    plan.push_back(row);
  endfunction

  function automatic void add_write(input int idx, input bit used);
    plan_row_t row;
    row                 = '{kind: ROW_WORD, default: '0};
    row.word.cmd        = afs_pkg::CMD_WRITE;
    row.word.map_index  = 10'(idx);
    row.word.map_used   = used;
    row.word.alloc_size = 11'($urandom_range(2047));
    plan.push_back(row);
  endfunction

  function automatic void add_search(input int size, input bit typed, input bit found,
                                     input logic [15:0] addr);
    plan_row_t row;
    row                    = '{kind: ROW_WORD, default: '0};
    row.word.cmd           = afs_pkg::CMD_ALLOC;
    row.word.map_index     = 10'($urandom_range(1023));
    row.word.map_used      = 1'($urandom_range(1));
    row.word.alloc_size    = 11'(size);
    row.typed              = typed;
    row.want.found         = found;
    row.want.block_address = addr;
    plan.push_back(row);
  endfunction

  // Hold start until the word is taken, queue its result, then idle at random
  task automatic send_word(input afs_pkg::in_t w, input bit typed, input afs_pkg::out_t want);
    bit            has;
    afs_pkg::out_t calc;
    in_word <= w;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    search_map(w, has, calc);
    word_count++;
    if (has) begin
      search_count++;
      if (calc.found) fit_count++;
      pending_blocks.push_back(typed ? want : calc);
    end else begin
      write_count++;
    end
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drain outstanding searches; a map write leaves no trace, so also pause after that
  task automatic settle();
    start <= 1'b0;
    while (pending_blocks.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] s, input logic [15:0] b,
                               input logic [10:0] l);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= afs_pkg::CFG_FIT_STRATEGY;
    cfg_data  <= {14'd0, s};
    @(posedge clk);
    cfg_index <= afs_pkg::CFG_AREA_BASE;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= afs_pkg::CFG_AREA_LENGTH;
    cfg_data  <= {5'd0, l};
    @(posedge clk);
    cfg_we      <= 1'b0;
    fit_q       = s;
    area_base_q = b;
    area_len_q  = int'(l);
    setting_count++;
  endtask

  // Random words under the current setting; fill sets how often a write marks used
  task automatic run_setting(input int n, input int fill);
    afs_pkg::in_t  w;
    afs_pkg::out_t none;
    int            len_eff;
    int            pick;
    none    = '0;
    len_eff = (area_len_q > MAP_ENTRIES) ? MAP_ENTRIES : area_len_q;
    repeat (n) begin
      w.map_index  = 10'($urandom_range(1023));
      w.map_used   = 1'($urandom_range(1));
      w.alloc_size = 11'($urandom_range(2047));
      if ($urandom_range(99) < 45) begin
        w.cmd = afs_pkg::CMD_WRITE;
        if (len_eff > 0 && $urandom_range(9) != 0) w.map_index = 10'($urandom_range(len_eff - 1));
        w.map_used = ($urandom_range(99) < fill);
      end else begin
        w.cmd = afs_pkg::CMD_ALLOC;
        pick  = $urandom_range(99);
        if (pick < 5) begin
          w.alloc_size = '0;
        end else if (pick < 12) begin
          // keep the full-field random size
        end else if (pick < 17) begin
          w.alloc_size = 11'(len_eff + 1);
        end else if (pick < 70 || len_eff < 2) begin
          w.alloc_size = 11'($urandom_range(1, 4));
        end else begin
          w.alloc_size = 11'($urandom_range(1, len_eff));
        end
      end
      send_word(w, 1'b0, none);
    end
  endtask

  // Result checker: every strobe must match the oldest outstanding search
  always @(posedge clk) begin : check_results
    afs_pkg::out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected result word: found %0b block_address %h",
               out_word.found, out_word.block_address);
        errors++;
      end else begin
        want = pending_blocks.pop_front();
        checked_count++;
        if (out_word.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_word.found);
          errors++;
        end
        if (out_word.block_address !== want.block_address) begin
          $error("block_address: expected %h, got %h",
                 want.block_address, out_word.block_address);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    int idle_by_phase [3];
    int len_pick;
    int base_pick;
    int guard;
    idle_by_phase = '{16, 82, 0};

    // Directed plan: empty map after reset, size extremes, clipping, wrap, each strategy
    add_search(0, 1'b1, 1'b0, 16'd0);
    add_search(1, 1'b1, 1'b1, 16'd0);
    add_search(1024, 1'b1, 1'b1, 16'd0);
    add_search(1025, 1'b1, 1'b0, 16'd0);
    add_search(2047, 1'b1, 1'b0, 16'd0);
    add_write(1023, 1'b1);
    add_search(1024, 1'b1, 1'b0, 16'd0);
    add_search(1023, 1'b1, 1'b1, 16'd0);
    // length over the map clips; base plus offset wraps
    add_setup(afs_pkg::FIT_FIRST, 16'hFFFF, 11'd2047);
    add_write(0, 1'b1);
    add_search(1, 1'b0, 1'b0, 16'd0);
    // empty use area
    add_setup(afs_pkg::FIT_FIRST, 16'd64511, 11'd0);
    add_search(1, 1'b1, 1'b0, 16'd0);
    // runs at 1..3, 5..6, 8..15
    add_setup(afs_pkg::FIT_BEST, 16'h0100, 11'd16);
    add_write(4, 1'b1);
    add_write(7, 1'b1);
    add_search(2, 1'b0, 1'b0, 16'd0);
    add_setup(afs_pkg::FIT_WORST, 16'h0100, 11'd16);
    add_search(2, 1'b0, 1'b0, 16'd0);
    // equal runs at 5..6 and 8..9: later one wins
    add_write(10, 1'b1);
    add_setup(afs_pkg::FIT_BEST, 16'h0100, 11'd16);
    add_search(2, 1'b0, 1'b0, 16'd0);
    // next fit: advance, miss from pointer and fall back, pointer past area, wrap to 0
    add_setup(afs_pkg::FIT_NEXT, 16'h0100, 11'd16);
    add_search(2, 1'b0, 1'b0, 16'd0);
    add_search(3, 1'b0, 1'b0, 16'd0);
    add_search(3, 1'b0, 1'b0, 16'd0);
    add_setup(afs_pkg::FIT_NEXT, 16'h0100, 11'd8);
    add_search(1, 1'b0, 1'b0, 16'd0);
    add_setup(afs_pkg::FIT_NEXT, 16'h0100, 11'd16);
    add_search(2, 1'b0, 1'b0, 16'd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    sender_idle = idle_by_phase[0];
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_SETUP) begin
        apply_setting(plan[k].strategy, plan[k].base, plan[k].length);
      end else begin
        send_word(plan[k].word, plan[k].typed, plan[k].want);
      end
    end

    // Random part: three idle rates, eight settings each, one large area per rate
    for (int p = 0; p < 3; p++) begin
      sender_idle = idle_by_phase[p];
      for (int s = 0; s < 8; s++) begin
        if (s == 7) begin
          len_pick = (p == 1) ? 2047 : 1024;
        end else if (s == 6) begin
          len_pick = (p == 0) ? 1 : (p == 1) ? 0 : 2;
        end else begin
          len_pick = $urandom_range(3, 64);
        end
        case (s)
          0:       base_pick = 0;
          1:       base_pick = 64511;
          2:       base_pick = 65535;
          default: base_pick = $urandom_range(65535);
        endcase
        apply_setting(2'((s + p) % 4), 16'(base_pick), 11'(len_pick));
        run_setting((s == 7) ? 8 : 22, $urandom_range(90));
      end
    end

    // Wait out the last searches, then watch for stray result words
    start <= 1'b0;
    guard = 0;
    while ((pending_blocks.size() != 0 || busy) && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
    if (pending_blocks.size() != 0) begin
      $error("%0d searches never answered", pending_blocks.size());
      errors++;
    end

    $display("Sent %0d words (%0d map writes, %0d searches, %0d predicted fits),",
             word_count, write_count, search_count, fit_count);
    $display("%0d results checked over %0d register settings: all strategies, base wrap.",
             checked_count, setting_count);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
